[rtl/sov_pkg.sv]
// Shared types, constants and the FNV-1a step for the sort output verifier.
`default_nettype none

package sov_pkg;

    localparam int KEY_MAX       = 64;
    localparam int COUNT_BITS    = 48;
    localparam int IDX_BITS      = 40;
    localparam int KEY_ADDR_BITS = $clog2(KEY_MAX);

    localparam logic [63:0]           FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [IDX_BITS-1:0]   IDX_MAX   = '1;

    localparam logic [15:0] RECORD_BYTES_RESET = 16'd100;
    localparam logic [6:0]  KEY_BYTES_RESET    = 7'd10;
    localparam logic [15:0] KEY_MAX_16         = 16'(KEY_MAX);

    localparam logic CFG_RECORD_BYTES = 1'b0;
    localparam logic CFG_KEY_BYTES    = 1'b1;

    typedef enum logic [1:0] {
        FUNC_SRC    = 2'd0,
        FUNC_DST    = 2'd1,
        FUNC_FINISH = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        CMP_EQUAL   = 2'd0,
        CMP_LESS    = 2'd1,
        CMP_GREATER = 2'd2
    } t_cmp;

    // Per-stream position status handed from a stream lane to the top level.
    typedef struct packed {
        logic [15:0] position;
        logic [15:0] next_position;
        logic        rec_end;
    } t_lane_stat;

    // One FNV-1a step. The prime 2^40 + 0x1b3 is applied as shifts and adds.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

[rtl/sov_in_if.sv]
// Input channel of the sort output verifier: one stream byte or a finish request.
`default_nettype none

interface sov_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

`default_nettype wire

[rtl/sov_out_if.sv]
// Result channel of the sort output verifier: one report per finish request.
`default_nettype none

interface sov_out_if;
    logic        valid;
    logic        ready;
    logic        sizes_equal;
    logic        aligned;
    logic        sorted_ok;
    logic [39:0] first_violation;
    logic [39:0] record_count;
    logic [63:0] source_sum;
    logic [63:0] sorted_sum;
    logic        sums_match;

    modport source (output valid, output sizes_equal, output aligned, output sorted_ok,
                    output first_violation, output record_count, output source_sum,
                    output sorted_sum, output sums_match, input ready);
    modport sink   (input valid, input sizes_equal, input aligned, input sorted_ok,
                    input first_violation, input record_count, input source_sum,
                    input sorted_sum, input sums_match, output ready);
endinterface

`default_nettype wire

[rtl/sov_stream.sv]
// One stream lane: record position, running record hash, hash sum and byte count.
`default_nettype none

module sov_stream import sov_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_byte_en,
    input  wire logic                  i_clear,
    input  wire logic [7:0]            i_byte,
    input  wire logic [15:0]           i_rec_len,
    output t_lane_stat                 o_stat,
    output logic      [63:0]           o_hash_sum,
    output logic      [COUNT_BITS-1:0] o_byte_count
);

    logic [15:0]           r_position, n_position;
    logic [63:0]           r_hash, n_hash;
    logic [63:0]           r_hash_sum, n_hash_sum;
    logic [COUNT_BITS-1:0] r_byte_count, n_byte_count;
    logic [63:0]           w_hash_byte;
    logic                  w_rec_end;

    assign w_hash_byte = fnv_step(r_hash, i_byte);
    assign w_rec_end   = ({1'b0, r_position} + 17'd1) >= {1'b0, i_rec_len};

    always_comb begin
        n_position   = r_position;
        n_hash       = r_hash;
        n_hash_sum   = r_hash_sum;
        n_byte_count = r_byte_count;
        if (i_clear) begin
            n_position   = '0;
            n_hash       = FNV_BASIS;
            n_hash_sum   = '0;
            n_byte_count = '0;
        end else if (i_byte_en) begin
            if (r_byte_count != COUNT_MAX) begin
                n_byte_count = r_byte_count + 1'b1;
            end
            if (w_rec_end) begin
                n_hash_sum = r_hash_sum + w_hash_byte;
                n_hash     = FNV_BASIS;
                n_position = '0;
            end else begin
                n_hash     = w_hash_byte;
                n_position = r_position + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position   <= '0;
            r_hash       <= FNV_BASIS;
            r_hash_sum   <= '0;
            r_byte_count <= '0;
        end else begin
            r_position   <= n_position;
            r_hash       <= n_hash;
            r_hash_sum   <= n_hash_sum;
            r_byte_count <= n_byte_count;
        end
    end

    assign o_stat.position      = r_position;
    assign o_stat.next_position = n_position;
    assign o_stat.rec_end       = w_rec_end;
    assign o_hash_sum           = r_hash_sum;
    assign o_byte_count         = r_byte_count;

endmodule

`default_nettype wire

[rtl/sort_output_verifier.sv]
// Sort output verifier top level: request staging, key order check and report register.
//
// Requests arrive on i_in, one byte of the source stream (func 0), one byte of the
// sorted stream (func 1) or a finish request (func 2); func 3 is dropped. Both streams
// are hashed record by record with FNV-1a 64 and the record hashes are summed. On the
// sorted stream the leading key bytes of each record are checked against the previous
// record. A finish request produces one report on o_out and then clears the hash and order-check state.
// Record and key lengths are written on the cfg port; the user must do so only while
// no request is in flight, as the block does not enforce it. Throughput is one request
// per cycle while no finish request waits on a stalled report: each request does one
// hash step on its stream and, for a sorted byte, one byte compare against the key
// memory, whose read for the next sorted byte is issued in advance. A finish report
// passes from the input register to the report register on its way to o_out. If the
// receiver stalls, the report holds, later bytes keep flowing, and a second finish
// request waits in the input register until the first report is taken. Synchronous
// reset clears all checking state and sets record_bytes to 100 and key_bytes to 10;
// the key memory needs no clearing since the first record of a run is never compared.
`default_nettype none

module sort_output_verifier import sov_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sov_in_if.sink           i_in,
    sov_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0] r_record_bytes;
    logic [6:0]  r_key_bytes;

    logic        r_in_valid;
    t_func       r_in_func;
    logic [7:0]  r_in_byte;

    logic        w_fire, w_src_en, w_dst_en, w_finish;
    logic [15:0] w_rec_len, w_key_cap, w_key_len;
    logic        w_in_key;
    logic [KEY_ADDR_BITS-1:0] w_wr_addr, w_rd_addr;

    t_lane_stat            w_src_stat, w_dst_stat;
    logic [63:0]           w_src_sum, w_dst_sum;
    logic [COUNT_BITS-1:0] w_src_count, w_dst_count;

    logic [7:0]  r_key_mem [KEY_MAX];
    logic [7:0]  r_key_rd;

    t_cmp                r_status, n_status;
    logic                r_violation_seen, n_violation_seen;
    logic [IDX_BITS-1:0] r_violation_index, n_violation_index;
    logic [IDX_BITS-1:0] r_record_index, n_record_index;

    logic                r_out_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_bytes <= RECORD_BYTES_RESET;
            r_key_bytes    <= KEY_BYTES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RECORD_BYTES: r_record_bytes <= i_cfg_data;
                CFG_KEY_BYTES:    r_key_bytes    <= i_cfg_data[6:0];
                default:          r_record_bytes <= r_record_bytes;
            endcase
        end
    end

    assign w_rec_len = (r_record_bytes == 16'd0) ? 16'd1 : r_record_bytes;
    assign w_key_cap = ({9'd0, r_key_bytes} > KEY_MAX_16) ? KEY_MAX_16 : {9'd0, r_key_bytes};
    assign w_key_len = (w_key_cap > w_rec_len) ? w_rec_len : w_key_cap;

    // A finish request only moves on when the report register can take it.
    assign w_fire     = r_in_valid && (r_in_func != FUNC_FINISH || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_func <= t_func'(i_in.func);
            r_in_byte <= i_in.data_byte;
        end
    end

    always_comb begin
        w_src_en = 1'b0;
        w_dst_en = 1'b0;
        w_finish = 1'b0;
        case (r_in_func)
            FUNC_SRC:    w_src_en = w_fire;
            FUNC_DST:    w_dst_en = w_fire;
            FUNC_FINISH: w_finish = w_fire;
            default:     w_finish = 1'b0;
        endcase
    end

    sov_stream u_src (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_en    (w_src_en),
        .i_clear      (w_finish),
        .i_byte       (r_in_byte),
        .i_rec_len    (w_rec_len),
        .o_stat       (w_src_stat),
        .o_hash_sum   (w_src_sum),
        .o_byte_count (w_src_count)
    );

    sov_stream u_dst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_en    (w_dst_en),
        .i_clear      (w_finish),
        .i_byte       (r_in_byte),
        .i_rec_len    (w_rec_len),
        .o_stat       (w_dst_stat),
        .o_hash_sum   (w_dst_sum),
        .o_byte_count (w_dst_count)
    );

    // Key memory. The read for the next sorted byte is issued at the position the
    // lane will hold next; a write to that same entry is forwarded.
    assign w_in_key  = w_dst_stat.position < w_key_len;
    assign w_wr_addr = w_dst_stat.position[KEY_ADDR_BITS-1:0];
    assign w_rd_addr = w_dst_stat.next_position[KEY_ADDR_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (w_dst_en && w_in_key) begin
            r_key_mem[w_wr_addr] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dst_en && w_in_key && w_wr_addr == w_rd_addr) begin
            r_key_rd <= r_in_byte;
        end else begin
            r_key_rd <= r_key_mem[w_rd_addr];
        end
    end

    // Order check on the sorted stream.
    always_comb begin
        n_status          = r_status;
        n_violation_seen  = r_violation_seen;
        n_violation_index = r_violation_index;
        n_record_index    = r_record_index;
        if (w_finish) begin
            n_status          = CMP_EQUAL;
            n_violation_seen  = 1'b0;
            n_violation_index = '0;
            n_record_index    = '0;
        end else if (w_dst_en) begin
            if (w_in_key && r_record_index != '0 && r_status == CMP_EQUAL) begin
                if (r_in_byte < r_key_rd) begin
                    n_status = CMP_LESS;
                end else if (r_in_byte > r_key_rd) begin
                    n_status = CMP_GREATER;
                end
            end
            if (w_dst_stat.rec_end) begin
                if (n_status == CMP_LESS && !r_violation_seen) begin
                    n_violation_seen  = 1'b1;
                    n_violation_index = r_record_index;
                end
                n_status = CMP_EQUAL;
                if (r_record_index != IDX_MAX) begin
                    n_record_index = r_record_index + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status          <= CMP_EQUAL;
            r_violation_seen  <= 1'b0;
            r_violation_index <= '0;
            r_record_index    <= '0;
        end else begin
            r_status          <= n_status;
            r_violation_seen  <= n_violation_seen;
            r_violation_index <= n_violation_index;
            r_record_index    <= n_record_index;
        end
    end

    // Report register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            o_out.sizes_equal     <= (w_src_count == w_dst_count);
            o_out.aligned         <= (w_src_stat.position == 16'd0)
                                     && (w_dst_stat.position == 16'd0);
            o_out.sorted_ok       <= !r_violation_seen;
            o_out.first_violation <= r_violation_index;
            o_out.record_count    <= r_record_index;
            o_out.source_sum      <= w_src_sum;
            o_out.sorted_sum      <= w_dst_sum;
            o_out.sums_match      <= (w_src_sum == w_dst_sum);
        end
    end

    assign o_out.valid = r_out_valid;

    // The first record is never compared, so a latched violation is never at index zero.
    a_violation_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.sorted_ok == (o_out.first_violation == '0)))
        else $error("report: sorted_ok disagrees with first_violation");

    a_violation_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_violation_seen |-> (r_violation_index <= r_record_index))
        else $error("violation index beyond record count");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (r_record_index == '0 && !r_violation_seen && r_status == CMP_EQUAL))
        else $error("finish request did not clear order state");

    a_finish_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> r_out_valid)
        else $error("finish request produced no report");

endmodule

`default_nettype wire

[test/sort_output_verifier_checker.sv]
// Checker for the sort output verifier: watches both channels, predicts each report and compares it.
`timescale 1ns / 1ps

module sort_output_verifier_checker import sov_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sov_in_if                i_in_mon,
    sov_out_if               i_out_mon,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output int               o_error_count,
    output int               o_pending_reports,
    output int               o_reports_checked
);

    localparam logic [63:0] FNV_PRIME  = 64'h100000001b3;
    localparam int          MAX_SHOWN  = 10;

    typedef struct packed {
        logic                sizes_equal;
        logic                aligned;
        logic                sorted_ok;
        logic [IDX_BITS-1:0] first_violation;
        logic [IDX_BITS-1:0] record_count;
        logic [63:0]         source_sum;
        logic [63:0]         sorted_sum;
        logic                sums_match;
    } report_t;

    // Configuration as last written.
    logic [15:0] cfg_record_bytes;
    logic [6:0]  cfg_key_bytes;

    // Running state of both streams.
    logic [15:0]           src_pos;
    logic [15:0]           dst_pos;
    logic [63:0]           src_hash_acc;
    logic [63:0]           dst_hash_acc;
    logic [63:0]           src_sum;
    logic [63:0]           dst_sum;
    logic [COUNT_BITS-1:0] src_count;
    logic [COUNT_BITS-1:0] dst_count;
    logic [IDX_BITS-1:0]   dst_index;
    logic [7:0]            key_store [KEY_MAX];
    t_cmp                  order_state;
    logic                  violation_flag;
    logic [IDX_BITS-1:0]   violation_at;

    report_t expected_reports [$];
    report_t want;
    report_t got;

    function automatic logic [63:0] fnv1a_mix(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * FNV_PRIME;
    endfunction

    // A record size of zero behaves as one byte.
    function automatic int unsigned record_len();
        return (cfg_record_bytes == 16'd0) ? 1 : int'(cfg_record_bytes);
    endfunction

    function automatic int unsigned compare_len();
        int unsigned k;
        k = cfg_key_bytes;
        if (k > KEY_MAX) k = KEY_MAX;
        if (k > record_len()) k = record_len();
        return k;
    endfunction

    task automatic clear_run();
        src_pos        = '0;
        dst_pos        = '0;
        src_hash_acc   = FNV_BASIS;
        dst_hash_acc   = FNV_BASIS;
        src_sum        = '0;
        dst_sum        = '0;
        src_count      = '0;
        dst_count      = '0;
        dst_index      = '0;
        order_state    = CMP_EQUAL;
        violation_flag = 1'b0;
        violation_at   = '0;
        for (int i = 0; i < KEY_MAX; i++) key_store[i] = 8'd0;
    endtask

    task automatic take_source_byte(input logic [7:0] b);
        src_hash_acc = fnv1a_mix(src_hash_acc, b);
        if (src_count != COUNT_MAX) src_count++;
        if (int'(src_pos) + 1 >= record_len()) begin
            src_sum      += src_hash_acc;
            src_hash_acc = FNV_BASIS;
            src_pos      = '0;
        end else begin
            src_pos++;
        end
    endtask

    task automatic take_sorted_byte(input logic [7:0] b);
        int unsigned p;
        p = dst_pos;
        dst_hash_acc = fnv1a_mix(dst_hash_acc, b);
        if (dst_count != COUNT_MAX) dst_count++;
        if (p < compare_len()) begin
            // The first record of a run only loads the key store.
            if (dst_index != '0 && order_state == CMP_EQUAL) begin
                if (b < key_store[p]) order_state = CMP_LESS;
                else if (b > key_store[p]) order_state = CMP_GREATER;
            end
            key_store[p] = b;
        end
        if (p + 1 >= record_len()) begin
            dst_sum      += dst_hash_acc;
            dst_hash_acc = FNV_BASIS;
            dst_pos      = '0;
            if (order_state == CMP_LESS && !violation_flag) begin
                violation_flag = 1'b1;
                violation_at   = dst_index;
            end
            order_state = CMP_EQUAL;
            if (dst_index != IDX_MAX) dst_index++;
        end else begin
            dst_pos++;
        end
    endtask

    task automatic take_finish();
        report_t r;
        r.sizes_equal     = (src_count == dst_count);
        r.aligned         = (src_pos == '0 && dst_pos == '0);
        r.sorted_ok       = !violation_flag;
        r.first_violation = violation_at;
        r.record_count    = dst_index;
        r.source_sum      = src_sum;
        r.sorted_sum      = dst_sum;
        r.sums_match      = (src_sum == dst_sum);
        expected_reports.push_back(r);
        clear_run();
    endtask

    task automatic check_field(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            o_error_count++;
            if (o_error_count <= MAX_SHOWN)
                $display("Report %0d: %s expected 'h%0h, got 'h%0h",
                         o_reports_checked, field, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_record_bytes = RECORD_BYTES_RESET;
            cfg_key_bytes    = KEY_BYTES_RESET;
            clear_run();
            expected_reports.delete();
            o_error_count     = 0;
            o_pending_reports = 0;
            o_reports_checked = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RECORD_BYTES) cfg_record_bytes = i_cfg_data;
                else cfg_key_bytes = i_cfg_data[6:0];
            end

            if (i_in_mon.valid && i_in_mon.ready) begin
                case (i_in_mon.func)
                    FUNC_SRC:    take_source_byte(i_in_mon.data_byte);
                    FUNC_DST:    take_sorted_byte(i_in_mon.data_byte);
                    FUNC_FINISH: take_finish();
                    default: ;
                endcase
            end

            if (i_out_mon.valid && i_out_mon.ready) begin
                got.sizes_equal     = i_out_mon.sizes_equal;
                got.aligned         = i_out_mon.aligned;
                got.sorted_ok       = i_out_mon.sorted_ok;
                got.first_violation = i_out_mon.first_violation;
                got.record_count    = i_out_mon.record_count;
                got.source_sum      = i_out_mon.source_sum;
                got.sorted_sum      = i_out_mon.sorted_sum;
                got.sums_match      = i_out_mon.sums_match;
                if (expected_reports.size() == 0) begin
                    o_error_count++;
                    if (o_error_count <= MAX_SHOWN)
                        $display("Report with no finish request waiting: sorted_sum 'h%0h",
                                 got.sorted_sum);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("sizes_equal", 64'(want.sizes_equal), 64'(got.sizes_equal));
                    check_field("aligned", 64'(want.aligned), 64'(got.aligned));
                    check_field("sorted_ok", 64'(want.sorted_ok), 64'(got.sorted_ok));
                    check_field("first_violation", 64'(want.first_violation),
                                64'(got.first_violation));
                    check_field("record_count", 64'(want.record_count),
                                64'(got.record_count));
                    check_field("source_sum", want.source_sum, got.source_sum);
                    check_field("sorted_sum", want.sorted_sum, got.sorted_sum);
                    check_field("sums_match", 64'(want.sums_match), 64'(got.sums_match));
                    o_reports_checked++;
                end
            end

            o_pending_reports = expected_reports.size();
        end
    end

endmodule

[test/sort_output_verifier_tb.sv]
// Testbench top for the sort output verifier: clock, reset, record stream stimulus and verdict.
`timescale 1ns / 1ps

module sort_output_verifier_tb;
    import sov_pkg::*;

    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         ITEM_TARGET  = 1950;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    int error_count;
    int pending_reports;
    int reports_checked;

    int          items_sent;
    int          set_index;
    int          faulty_sets;
    int          rb_low;
    int          rb_high;
    logic [15:0] cur_rb;
    logic [6:0]  cur_kb;
    bit          quiet;

    sov_in_if  in_if ();
    sov_out_if out_if ();

    sort_output_verifier u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sort_output_verifier_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_mon          (in_if),
        .i_out_mon         (out_if),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_error_count     (error_count),
        .o_pending_reports (pending_reports),
        .o_reports_checked (reports_checked)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #(2_000_000);
        $display("FAILURE");
        $finish;
    end

    // The report receiver stalls at random, except during the quiet stretch.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= quiet || ($urandom_range(0, 99) >= 32);
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_item(input logic [1:0] f, input logic [7:0] b);
        while (!quiet && $urandom_range(0, 99) < 32) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.func      <= f;
        in_if.data_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (f != FUNC_UNUSED) items_sent++;
        @(negedge i_clk);
    endtask

    // Hold off new requests until every report has come back and the pipeline is empty.
    task automatic wait_for_reports();
        in_if.valid <= 1'b0;
        while (pending_reports != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes both registers on back-to-back cycles; the block must be idle.
    task automatic set_config(input logic [15:0] rb, input logic [6:0] kb);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RECORD_BYTES;
        cfg_data  <= rb;
        @(negedge i_clk);
        cfg_index <= CFG_KEY_BYTES;
        cfg_data  <= {9'($urandom), kb};
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cur_rb = rb;
        cur_kb = kb;
        if (int'(rb) < rb_low) rb_low = rb;
        if (int'(rb) > rb_high) rb_high = rb;
    endtask

    // Builds a set of records, sorts a copy by key, optionally breaks it,
    // interleaves both streams and closes with a finish request.
    task automatic run_record_set(input int unsigned n_rec, input int unsigned rec_len,
                                  input int unsigned key_len, input bit fault);
        logic [7:0]  src_data [$];
        logic [7:0]  dst_data [$];
        int unsigned order [$];
        int unsigned i, j, k, a, b, tmp, si, di;
        int          cmp;
        logic [7:0]  v;
        for (i = 0; i < n_rec; i++) begin
            for (k = 0; k < rec_len; k++) begin
                // Key bytes mostly come from a tiny alphabet so that keys often share prefixes.
                if (k < key_len && $urandom_range(0, 3) != 0) v = 8'($urandom_range(0, 2) * 127);
                else v = 8'($urandom);
                src_data.push_back(v);
            end
            order.push_back(i);
        end
        for (i = 1; i < n_rec; i++) begin
            j = i;
            while (j > 0) begin
                cmp = 0;
                for (k = 0; k < key_len && cmp == 0; k++) begin
                    a = src_data[order[j] * rec_len + k];
                    b = src_data[order[j - 1] * rec_len + k];
                    if (a < b) cmp = -1;
                    else if (a > b) cmp = 1;
                end
                if (cmp >= 0) break;
                tmp          = order[j];
                order[j]     = order[j - 1];
                order[j - 1] = tmp;
                j--;
            end
        end
        for (i = 0; i < n_rec; i++)
            for (k = 0; k < rec_len; k++)
                dst_data.push_back(src_data[order[i] * rec_len + k]);

        if (fault && n_rec > 0) begin
            faulty_sets++;
            case ($urandom_range(0, 3))
                0: begin
                    a = $urandom_range(0, n_rec - 1);
                    b = $urandom_range(0, n_rec - 1);
                    for (k = 0; k < rec_len; k++) begin
                        v                          = dst_data[a * rec_len + k];
                        dst_data[a * rec_len + k]  = dst_data[b * rec_len + k];
                        dst_data[b * rec_len + k]  = v;
                    end
                end
                1: begin
                    a = $urandom_range(0, dst_data.size() - 1);
                    dst_data[a] = dst_data[a] ^ 8'(1 << $urandom_range(0, 7));
                end
                2: repeat ($urandom_range(1, dst_data.size())) void'(dst_data.pop_back());
                default: repeat ($urandom_range(1, rec_len + 2))
                    src_data.push_back(8'($urandom));
            endcase
        end

        si = 0;
        di = 0;
        while (si < src_data.size() || di < dst_data.size()) begin
            if ($urandom_range(0, 39) == 0) send_item(FUNC_UNUSED, 8'($urandom));
            if (di >= dst_data.size() || (si < src_data.size() && $urandom_range(0, 1) == 1)) begin
                send_item(FUNC_SRC, src_data[si]);
                si++;
            end else begin
                send_item(FUNC_DST, dst_data[di]);
                di++;
            end
        end
        send_item(FUNC_FINISH, 8'($urandom));
    endtask

    // Unstructured bytes of any selector, then a finish request.
    task automatic run_noise_set();
        repeat ($urandom_range(5, 40)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
        send_item(FUNC_FINISH, 8'($urandom));
    endtask

    // Starts records at one size and lowers the size in the middle of the run.
    // The key length is kept, so the compared length can only shrink.
    task automatic run_resize_set();
        logic [15:0] rb_hi;
        logic [6:0]  kb;
        rb_hi = 16'($urandom_range(4, 12));
        kb    = 7'($urandom_range(1, rb_hi + 2));
        wait_for_reports();
        set_config(rb_hi, kb);
        repeat ($urandom_range(1, 3 * rb_hi))
            send_item(2'($urandom_range(0, 1)), 8'($urandom_range(0, 2) * 127));
        wait_for_reports();
        set_config(16'($urandom_range(1, rb_hi - 1)), kb);
        repeat ($urandom_range(1, 3 * rb_hi))
            send_item(2'($urandom_range(0, 1)), 8'($urandom_range(0, 2) * 127));
        send_item(FUNC_FINISH, 8'($urandom));
    endtask

    initial begin
        logic [15:0] rb;
        logic [6:0]  kb;
        int unsigned eff_rec;
        int unsigned eff_key;
        int unsigned kind;
        int unsigned n_rec;

        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.func      = FUNC_SRC;
        in_if.data_byte = 8'd0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_RECORD_BYTES;
        cfg_data        = 16'd0;
        quiet           = 1'b0;
        items_sent      = 0;
        set_index       = 0;
        faulty_sets     = 0;
        cur_rb          = RECORD_BYTES_RESET;
        cur_kb          = KEY_BYTES_RESET;
        rb_low          = RECORD_BYTES_RESET;
        rb_high         = RECORD_BYTES_RESET;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty run under the reset configuration.
        send_item(FUNC_FINISH, 8'h00);

        // One-byte records: the second key is smaller, and the unused selector is dropped.
        wait_for_reports();
        set_config(16'd1, 7'd1);
        send_item(FUNC_UNUSED, 8'hff);
        send_item(FUNC_SRC, 8'h00);
        send_item(FUNC_SRC, 8'hff);
        send_item(FUNC_DST, 8'hff);
        send_item(FUNC_DST, 8'h00);
        send_item(FUNC_FINISH, 8'hff);

        // Record size zero acts as one byte; key length zero accepts any order.
        wait_for_reports();
        set_config(16'd0, 7'd0);
        send_item(FUNC_DST, 8'h10);
        send_item(FUNC_DST, 8'h05);
        send_item(FUNC_SRC, 8'h05);
        send_item(FUNC_FINISH, 8'h00);

        // Largest record and key settings; only partial records.
        wait_for_reports();
        set_config(16'hffff, 7'h7f);
        send_item(FUNC_SRC, 8'hab);
        send_item(FUNC_DST, 8'hab);
        send_item(FUNC_FINISH, 8'h00);

        // Record size lowered below the current position ends the record on the next byte.
        wait_for_reports();
        set_config(16'd4, 7'd64);
        send_item(FUNC_DST, 8'h01);
        send_item(FUNC_DST, 8'h02);
        send_item(FUNC_DST, 8'h03);
        wait_for_reports();
        set_config(16'd2, 7'd64);
        send_item(FUNC_DST, 8'h00);
        send_item(FUNC_DST, 8'h00);
        send_item(FUNC_DST, 8'h05);
        send_item(FUNC_FINISH, 8'h00);

        while (items_sent < ITEM_TARGET) begin
            quiet = (set_index >= 20 && set_index < 32);
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       rb = 16'd0;
                    1:       rb = 16'($urandom_range(65, 65535));
                    2:       rb = 16'($urandom_range(9, 32));
                    default: rb = 16'($urandom_range(1, 8));
                endcase
                case ($urandom_range(0, 5))
                    0:       kb = 7'd0;
                    1:       kb = 7'd64;
                    2:       kb = 7'($urandom_range(65, 127));
                    3:       kb = 7'd1;
                    default: kb = 7'($urandom_range(1, (rb > 16'd100) ? 101 : int'(rb) + 1));
                endcase
                wait_for_reports();
                set_config(rb, kb);
            end else if ($urandom_range(0, 9) == 0) begin
                wait_for_reports();
            end

            eff_rec = (cur_rb == 16'd0) ? 1 : cur_rb;
            eff_key = cur_kb;
            if (eff_key > KEY_MAX) eff_key = KEY_MAX;
            if (eff_key > eff_rec) eff_key = eff_rec;
            n_rec = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);

            kind = $urandom_range(0, 19);
            if (eff_rec > 64 || kind < 2) run_noise_set();
            else if (kind < 3) run_resize_set();
            else run_record_set(n_rec, eff_rec, eff_key, kind < 9);
            set_index++;
        end

        quiet = 1'b0;
        wait_for_reports();
        repeat (2 * DRAIN_CYCLES) @(negedge i_clk);

        $display("Checked %0d reports from %0d requests in %0d record sets, %0d with faults.",
                 reports_checked, items_sent, set_index, faulty_sets);
        $display("Record sizes from %0d to %0d bytes were configured, with key lengths 0 to 127.",
                 rb_low, rb_high);
        if (error_count == 0 && pending_reports == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
rtl/sov_pkg.sv
rtl/sov_in_if.sv
rtl/sov_out_if.sv
rtl/sov_stream.sv
rtl/sort_output_verifier.sv
test/sort_output_verifier_checker.sv
test/sort_output_verifier_tb.sv
